// ===== design/sgmpca_pkg.sv =====
// Shared types and constants for the SGM path cost aggregation block.
// Used by every module in design/; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package sgmpca_pkg;

   localparam int MAX_DISPARITIES_DEFAULT = 64;

   localparam int COST_W      = 8;
   localparam int GRAY_W      = 8;
   localparam int P1_W        = 8;
   localparam int P2_W        = 10;
   localparam int COUNT_W     = 7;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 10;
   localparam int DIV_STEP_W  = 4;

   localparam logic [COST_W-1:0]  COST_MAX            = 8'hFF;
   localparam logic [P1_W-1:0]    PENALTY_SMALL_RESET = 8'd10;
   localparam logic [P2_W-1:0]    PENALTY_LARGE_RESET = 10'd150;
   localparam logic [COUNT_W-1:0] COUNT_RESET         = 7'd64;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PENALTY_SMALL      = 2'd0,
      CSR_PENALTY_LARGE_BASE = 2'd1,
      CSR_DISPARITY_COUNT    = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [COST_W-1:0] raw_cost;
      logic [GRAY_W-1:0] pixel_gray;
      logic              path_start;
   } req_word_type;

   typedef struct packed {
      logic [COST_W-1:0] aggregated_cost;
      logic              pixel_done;
      logic [COST_W-1:0] pixel_min;
   } rsp_word_type;

   typedef struct packed {
      logic first;
      logic last;
   } tag_type;

endpackage

`default_nettype wire

// ===== design/sgm_path_cost_aggregation.sv =====
// SGM path cost aggregation, one disparity word per request.
// Requests pass the front end and the two-entry queue; the back end runs the 10-step
// penalty divider on a pixel's first disparity, three reads of the single cost memory
// read port, the best-cost pick and the write to the result register; path-start words
// skip the reads and the pick. The back end takes a new word only once it is idle again.
// Reset: synchronous, clears control, loads register defaults; cost memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module sgm_path_cost_aggregation import sgmpca_pkg::*; #(
   parameter int MAX_DISPARITIES = MAX_DISPARITIES_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire req_word_type           req_word,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output rsp_word_type                rsp_word
);

   localparam int DISP_W = $clog2(MAX_DISPARITIES);
   localparam int DATA_W = DISP_W + $bits(tag_type) + $bits(req_word_type);

   logic [P1_W-1:0]    penalty_small_ff, penalty_small_in;
   logic [P2_W-1:0]    penalty_large_ff, penalty_large_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic              push_valid, push_stall, pop_valid, pop_stall;
   req_word_type      push_word, pop_word;
   tag_type           push_tag, pop_tag;
   logic [DISP_W-1:0] push_disp, pop_disp;
   logic [DATA_W-1:0] push_data, pop_data;

   always_comb begin
      penalty_small_in = penalty_small_ff;
      penalty_large_in = penalty_large_ff;
      count_in         = count_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_PENALTY_SMALL:      penalty_small_in = csr_wdata[P1_W-1:0];
            CSR_PENALTY_LARGE_BASE: penalty_large_in = csr_wdata[P2_W-1:0];
            CSR_DISPARITY_COUNT:    count_in         = csr_wdata[COUNT_W-1:0];
            default:                count_in         = count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         penalty_small_ff <= PENALTY_SMALL_RESET;
         penalty_large_ff <= PENALTY_LARGE_RESET;
         count_ff         <= COUNT_RESET;
      end else begin
         penalty_small_ff <= penalty_small_in;
         penalty_large_ff <= penalty_large_in;
         count_ff         <= count_in;
      end
   end

   sgmpca_front #(
      .MAX_DISPARITIES(MAX_DISPARITIES)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .disparity_count (count_ff),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_word        (req_word),
      .push_valid      (push_valid),
      .push_stall      (push_stall),
      .push_word       (push_word),
      .push_tag        (push_tag),
      .push_disp       (push_disp)
   );

   assign push_data = {push_disp, push_tag, push_word};

   sgmpca_queue #(
      .DATA_W(DATA_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_stall (push_stall),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_stall  (pop_stall),
      .pop_data   (pop_data)
   );

   assign {pop_disp, pop_tag, pop_word} = pop_data;

   sgmpca_back #(
      .MAX_DISPARITIES(MAX_DISPARITIES)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .penalty_small      (penalty_small_ff),
      .penalty_large_base (penalty_large_ff),
      .pop_valid          (pop_valid),
      .pop_stall          (pop_stall),
      .pop_word           (pop_word),
      .pop_tag            (pop_tag),
      .pop_disp           (pop_disp),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_word           (rsp_word)
   );

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.pixel_done |-> rsp_word.pixel_min == '0)
      else $error("pixel_min set on a word that does not end the pixel");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.pixel_done |-> rsp_word.pixel_min <= rsp_word.aggregated_cost)
      else $error("pixel_min above the last cost of the pixel");

   assert property (@(posedge clock) disable iff (reset)
      pop_valid && pop_tag.first |-> pop_disp == '0)
      else $error("first disparity word carries a nonzero index");
`endif

endmodule

`default_nettype wire

// ===== design/sgmpca_front.sv =====
// Front end: accepts request words, tracks the disparity index and tags
// first and last disparity of each pixel. Depends on sgmpca_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sgmpca_front import sgmpca_pkg::*; #(
   parameter int MAX_DISPARITIES = MAX_DISPARITIES_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic [COUNT_W-1:0]                   disparity_count,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire req_word_type                         req_word,
   output logic                                      push_valid,
   input  wire logic                                 push_stall,
   output req_word_type                              push_word,
   output tag_type                                   push_tag,
   output logic [$clog2(MAX_DISPARITIES)-1:0]        push_disp
);

   localparam int DISP_W = $clog2(MAX_DISPARITIES);
   localparam int CNT_W  = (DISP_W + 1 > COUNT_W) ? DISP_W + 1 : COUNT_W;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DISPARITIES);

   logic [DISP_W-1:0] disp_ff, disp_in;
   logic [CNT_W-1:0]  count_ext, eff_count, disp_next;
   logic              last, accept;

   assign count_ext = CNT_W'(disparity_count);

   always_comb begin
      priority if (count_ext == '0) begin
         eff_count = CNT_W'(1);
      end else if (count_ext > MAX_CNT) begin
         eff_count = MAX_CNT;
      end else begin
         eff_count = count_ext;
      end
   end

   assign disp_next = CNT_W'(disp_ff) + CNT_W'(1);
   assign last      = disp_next >= eff_count;
   assign accept    = req_valid && !push_stall;

   always_comb begin
      disp_in = disp_ff;
      if (accept) begin
         disp_in = last ? '0 : disp_next[DISP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         disp_ff <= '0;
      end else begin
         disp_ff <= disp_in;
      end
   end

   assign req_stall      = push_stall;
   assign push_valid     = req_valid;
   assign push_word      = req_word;
   assign push_tag.first = (disp_ff == '0);
   assign push_tag.last  = last;
   assign push_disp      = disp_ff;

endmodule

`default_nettype wire

// ===== design/sgmpca_queue.sv =====
// Two-entry queue between front and back end.
// Depends on sgmpca_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sgmpca_queue import sgmpca_pkg::*; #(
   parameter int DATA_W = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   output logic                   push_stall,
   input  wire logic [DATA_W-1:0] push_data,
   output logic                   pop_valid,
   input  wire logic              pop_stall,
   output logic [DATA_W-1:0]      pop_data
);

   logic [DATA_W-1:0] slot_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        fill_ff, fill_in;
   logic              push, pop;

   assign push_stall = (fill_ff == 2'd2);
   assign pop_valid  = (fill_ff != 2'd0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && !push_stall;
   assign pop        = pop_valid && !pop_stall;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== design/sgmpca_back.sv =====
// Back end: penalty divider, cost memory (two banks), path cost update
// and result register. Depends on sgmpca_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sgmpca_back import sgmpca_pkg::*; #(
   parameter int MAX_DISPARITIES = MAX_DISPARITIES_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic [P1_W-1:0]                      penalty_small,
   input  wire logic [P2_W-1:0]                      penalty_large_base,
   input  wire logic                                 pop_valid,
   output logic                                      pop_stall,
   input  wire req_word_type                         pop_word,
   input  wire tag_type                              pop_tag,
   input  wire logic [$clog2(MAX_DISPARITIES)-1:0]   pop_disp,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output rsp_word_type                              rsp_word
);

   localparam int DISP_W = $clog2(MAX_DISPARITIES);
   localparam int ADDR_W = DISP_W + 1;
   localparam int DEPTH  = 2 ** ADDR_W;
   localparam int SLOTS  = 2 ** DISP_W;
   localparam int DIVR_W = GRAY_W + 1;
   localparam int CAND_W = P2_W + 1;

   typedef enum logic [6:0] {
      ST_IDLE      = 7'b0000001,
      ST_DIVIDE    = 7'b0000010,
      ST_FETCH_LO  = 7'b0000100,
      ST_FETCH_MID = 7'b0001000,
      ST_FETCH_HI  = 7'b0010000,
      ST_BEST      = 7'b0100000,
      ST_WRITE     = 7'b1000000
   } back_state_type;

   back_state_type state_ff, state_in;

   req_word_type      item_word_ff, item_word_in;
   tag_type           item_tag_ff, item_tag_in;
   logic [DISP_W-1:0] item_disp_ff, item_disp_in;

   logic [SLOTS-1:0]  sel_ff, sel_in;
   logic [COST_W-1:0] prev_min_ff, prev_min_in;
   logic [COST_W-1:0] run_min_ff, run_min_in;
   logic [GRAY_W-1:0] prev_gray_ff, prev_gray_in;
   logic [P2_W-1:0]   large_pen_ff, large_pen_in;

   logic [DIVR_W-1:0]     divisor_ff, divisor_in;
   logic [P2_W-1:0]       num_ff, num_in;
   logic [DIVR_W-1:0]     rem_ff, rem_in;
   logic [P2_W-1:0]       quot_ff, quot_in;
   logic [DIV_STEP_W-1:0] step_ff, step_in;

   logic [COST_W-1:0] lo_ff, lo_in;
   logic [COST_W-1:0] mid_ff, mid_in;
   logic [COST_W-1:0] best_ff, best_in;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_word_type      rsp_word_ff, rsp_word_in;

   logic [COST_W-1:0] cost_mem [DEPTH];
   logic [COST_W-1:0] rd_data_ff;
   logic [DISP_W-1:0] rd_disp;
   logic              rd_bank;
   logic [ADDR_W-1:0] rd_addr, wr_addr;
   logic              wr_en;

   logic [GRAY_W-1:0] gray_diff;
   logic [DIVR_W:0]   trial, trial_sub;
   logic              qbit;
   logic [COST_W-1:0] lo_eff, hi_eff;
   logic [P2_W-1:0]   jump;
   logic [CAND_W-1:0] cand_mid, cand_lo, cand_hi, cand_jump, min_a, min_b, best_wide;
   logic [COST_W-1:0] result, new_min;
   logic              out_free;

   assign gray_diff = (pop_word.pixel_gray >= prev_gray_ff)
                    ? pop_word.pixel_gray - prev_gray_ff
                    : prev_gray_ff - pop_word.pixel_gray;

   assign trial     = {rem_ff, num_ff[P2_W-1]};
   assign trial_sub = trial - {1'b0, divisor_ff};
   assign qbit      = (trial >= {1'b0, divisor_ff});

   assign lo_eff    = item_tag_ff.first ? COST_MAX : lo_ff;
   assign hi_eff    = item_tag_ff.last ? COST_MAX : rd_data_ff;
   assign jump      = (large_pen_ff > P2_W'(penalty_small)) ? large_pen_ff
                                                            : P2_W'(penalty_small);
   assign cand_mid  = CAND_W'(mid_ff);
   assign cand_lo   = CAND_W'(lo_eff) + CAND_W'(penalty_small);
   assign cand_hi   = CAND_W'(hi_eff) + CAND_W'(penalty_small);
   assign cand_jump = CAND_W'(prev_min_ff) + CAND_W'(jump);
   assign min_a     = (cand_lo < cand_mid) ? cand_lo : cand_mid;
   assign min_b     = (cand_jump < cand_hi) ? cand_jump : cand_hi;
   assign best_wide = (min_b < min_a) ? min_b : min_a;

   assign result  = item_word_ff.path_start ? item_word_ff.raw_cost
                  : item_word_ff.raw_cost + (best_ff - prev_min_ff);
   assign new_min = (result < run_min_ff) ? result : run_min_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      unique case (state_ff)
         ST_FETCH_LO:  rd_disp = item_disp_ff - DISP_W'(1);
         ST_FETCH_HI:  rd_disp = item_disp_ff + DISP_W'(1);
         default:      rd_disp = item_disp_ff;
      endcase
   end

   // each slot points at the bank written last; the lower neighbor was already
   // rewritten in this pixel, so read its other bank
   assign rd_bank = (state_ff == ST_FETCH_LO) ? !sel_ff[rd_disp] : sel_ff[rd_disp];
   assign rd_addr = {rd_bank, rd_disp};
   assign wr_addr = {!sel_ff[item_disp_ff], item_disp_ff};

   always_comb begin
      state_in     = state_ff;
      item_word_in = item_word_ff;
      item_tag_in  = item_tag_ff;
      item_disp_in = item_disp_ff;
      sel_in       = sel_ff;
      prev_min_in  = prev_min_ff;
      run_min_in   = run_min_ff;
      prev_gray_in = prev_gray_ff;
      large_pen_in = large_pen_ff;
      divisor_in   = divisor_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      step_in      = step_ff;
      lo_in        = lo_ff;
      mid_in       = mid_ff;
      best_in      = best_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      wr_en        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               item_word_in = pop_word;
               item_tag_in  = pop_tag;
               item_disp_in = pop_disp;
               divisor_in   = DIVR_W'(gray_diff) + DIVR_W'(1);
               num_in       = penalty_large_base;
               rem_in       = '0;
               quot_in      = '0;
               step_in      = '0;
               priority if (pop_tag.first) begin
                  state_in = ST_DIVIDE;
               end else if (pop_word.path_start) begin
                  state_in = ST_WRITE;
               end else begin
                  state_in = ST_FETCH_LO;
               end
            end
         end
         ST_DIVIDE: begin
            rem_in  = qbit ? trial_sub[DIVR_W-1:0] : trial[DIVR_W-1:0];
            quot_in = {quot_ff[P2_W-2:0], qbit};
            num_in  = {num_ff[P2_W-2:0], 1'b0};
            step_in = step_ff + DIV_STEP_W'(1);
            if (step_ff == DIV_STEP_W'(P2_W - 1)) begin
               large_pen_in = {quot_ff[P2_W-2:0], qbit};
               state_in     = item_word_ff.path_start ? ST_WRITE : ST_FETCH_LO;
            end
         end
         ST_FETCH_LO: begin
            state_in = ST_FETCH_MID;
         end
         ST_FETCH_MID: begin
            lo_in    = rd_data_ff;
            state_in = ST_FETCH_HI;
         end
         ST_FETCH_HI: begin
            mid_in   = rd_data_ff;
            state_in = ST_BEST;
         end
         ST_BEST: begin
            best_in  = best_wide[COST_W-1:0];
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (out_free) begin
               wr_en                       = 1'b1;
               sel_in[item_disp_ff]        = !sel_ff[item_disp_ff];
               rsp_valid_in                = 1'b1;
               rsp_word_in.aggregated_cost = result;
               rsp_word_in.pixel_done      = item_tag_ff.last;
               rsp_word_in.pixel_min       = item_tag_ff.last ? new_min : '0;
               if (item_tag_ff.last) begin
                  prev_min_in  = new_min;
                  run_min_in   = COST_MAX;
                  prev_gray_in = item_word_ff.pixel_gray;
               end else begin
                  run_min_in = new_min;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sel_ff       <= '0;
         prev_min_ff  <= COST_MAX;
         run_min_ff   <= COST_MAX;
         prev_gray_ff <= '0;
         large_pen_ff <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         prev_min_ff  <= prev_min_in;
         run_min_ff   <= run_min_in;
         prev_gray_ff <= prev_gray_in;
         large_pen_ff <= large_pen_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_word_ff <= item_word_in;
      item_tag_ff  <= item_tag_in;
      item_disp_ff <= item_disp_in;
      divisor_ff   <= divisor_in;
      num_ff       <= num_in;
      rem_ff       <= rem_in;
      quot_ff      <= quot_in;
      lo_ff        <= lo_in;
      mid_ff       <= mid_in;
      best_ff      <= best_in;
      rsp_word_ff  <= rsp_word_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cost_mem[wr_addr] <= result;
      end
      rd_data_ff <= cost_mem[rd_addr];
   end

   assign pop_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

`default_nettype wire

// ===== sim/sgm_cost_checker.sv =====
// Scoreboard for the SGM path cost aggregation block: watches the register port and both
// word channels, predicts every aggregated cost word and compares it field by field.
// Depends on sgmpca_pkg for the word types and register indexes.
`timescale 1ns / 1ps

module sgm_cost_checker import sgmpca_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  req_word_type           req_word,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  rsp_word_type           rsp_word,
   output int                     mismatch_count,
   output int                     words_in_flight
);

   localparam int DEPTH = MAX_DISPARITIES_DEFAULT;

   logic [COST_W-1:0] prev_costs [DEPTH];
   logic [COST_W-1:0] curr_costs [DEPTH];
   int                prev_min;
   int                run_min;
   int                last_gray;
   int                disp_pos;
   int                big_penalty;
   int                small_penalty;
   int                large_base;
   int                count_reg;
   rsp_word_type      expected_costs [$];

   always @(posedge clock) begin : track
      int           d;
      int           cnt;
      int           gray;
      int           diff;
      int           same;
      int           lower;
      int           upper;
      int           jump;
      int           best;
      int           result;
      bit           done;
      rsp_word_type want;

      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            prev_costs[i] = '0;
            curr_costs[i] = '0;
         end
         prev_min       = 255;
         run_min        = 255;
         last_gray      = 0;
         disp_pos       = 0;
         big_penalty    = 0;
         small_penalty  = PENALTY_SMALL_RESET;
         large_base     = PENALTY_LARGE_RESET;
         count_reg      = COUNT_RESET;
         mismatch_count = 0;
         expected_costs.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_costs.size() == 0) begin
               $error("response word %h arrived with nothing expected", rsp_word);
               mismatch_count++;
            end else begin
               want = expected_costs.pop_front();
               if (rsp_word.aggregated_cost !== want.aggregated_cost) begin
                  $error("aggregated_cost: expected %0d, actual %0d",
                         want.aggregated_cost, rsp_word.aggregated_cost);
                  mismatch_count++;
               end
               if (rsp_word.pixel_done !== want.pixel_done) begin
                  $error("pixel_done: expected %0d, actual %0d",
                         want.pixel_done, rsp_word.pixel_done);
                  mismatch_count++;
               end
               if (rsp_word.pixel_min !== want.pixel_min) begin
                  $error("pixel_min: expected %0d, actual %0d",
                         want.pixel_min, rsp_word.pixel_min);
                  mismatch_count++;
               end
            end
         end

         if (csr_write_en) begin
            case (csr_index)
               CSR_PENALTY_SMALL:      small_penalty = csr_wdata[P1_W-1:0];
               CSR_PENALTY_LARGE_BASE: large_base    = csr_wdata[P2_W-1:0];
               CSR_DISPARITY_COUNT:    count_reg     = csr_wdata[COUNT_W-1:0];
               default: ;
            endcase
         end

         if (req_valid && !req_stall) begin
            d    = (disp_pos >= DEPTH) ? DEPTH - 1 : disp_pos;
            cnt  = (count_reg == 0) ? 1 : (count_reg > DEPTH) ? DEPTH : count_reg;
            gray = req_word.pixel_gray;
            if (d == 0) begin
               diff        = (gray >= last_gray) ? gray - last_gray : last_gray - gray;
               big_penalty = large_base / (diff + 1);
            end
            if (req_word.path_start) begin
               result = req_word.raw_cost;
            end else begin
               same  = prev_costs[d];
               lower = (d == 0) ? 255 : prev_costs[d - 1];
               upper = (d + 1 >= cnt) ? 255 : prev_costs[d + 1];
               jump  = (big_penalty > small_penalty) ? big_penalty : small_penalty;
               best  = same;
               if (lower + small_penalty < best) best = lower + small_penalty;
               if (upper + small_penalty < best) best = upper + small_penalty;
               if (prev_min + jump < best) best = prev_min + jump;
               result = (int'(req_word.raw_cost) + ((best - prev_min) & 255)) & 255;
            end
            curr_costs[d] = result[COST_W-1:0];
            if (result < run_min) run_min = result;
            done = (d + 1 >= cnt);
            want.aggregated_cost = result[COST_W-1:0];
            want.pixel_done      = done;
            want.pixel_min       = done ? run_min[COST_W-1:0] : '0;
            expected_costs.insert(expected_costs.size(), want);
            if (done) begin
               prev_costs = curr_costs;
               prev_min   = run_min;
               run_min    = 255;
               last_gray  = gray;
               disp_pos   = 0;
            end else begin
               disp_pos = d + 1;
            end
         end
      end
      words_in_flight = expected_costs.size();
   end

endmodule

// ===== sim/tb_top.sv =====
// Top level of the SGM path cost aggregation testbench: clock, reset, register writes,
// directed and random cost words with random idling on both channels, and the verdict.
// Depends on sgmpca_pkg, sgm_path_cost_aggregation and sgm_cost_checker.
`timescale 1ns / 1ps

module tb_top;
   import sgmpca_pkg::*;

   logic                   clock;
   logic                   reset;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   logic                   req_valid;
   logic                   req_stall;
   req_word_type           req_word;
   logic                   rsp_valid;
   logic                   rsp_stall;
   rsp_word_type           rsp_word;
   int                     mismatch_count;
   int                     words_in_flight;

   // sender-side view of the disparity position and of which cost entries hold data
   int                     trk_pos      = 0;
   int                     trk_count    = MAX_DISPARITIES_DEFAULT;
   bit [63:0]              curr_seen    = '0;
   bit [63:0]              prev_seen    = '0;
   logic [7:0]             last_gray    = '0;
   int                     words_sent   = 0;
   int                     pixels_sent  = 0;
   int                     settings_used = 0;
   bit                     idling_on    = 1'b1;
   bit                     rsp_free     = 1'b0;

   sgm_path_cost_aggregation uut (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_word     (req_word),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_word     (rsp_word)
   );

   sgm_cost_checker cost_check (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_word        (req_word),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_word        (rsp_word),
      .mismatch_count  (mismatch_count),
      .words_in_flight (words_in_flight)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   initial begin
      #(10_000_000);
      $display("Some tests failed");
      $finish;
   end

   initial begin : rsp_side
      int go;
      int hold;
      int r;
      rsp_stall = 1'b0;
      forever begin
         go   = $urandom_range(1, 8);
         r    = $urandom_range(0, 99);
         hold = (rsp_free || r < 40) ? 0 : (r < 88) ? $urandom_range(1, 3)
                                                    : $urandom_range(8, 40);
         repeat (go) begin
            @(negedge clock);
            rsp_stall <= 1'b0;
         end
         repeat (hold) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
      end
   end

   function automatic logic [7:0] pick_cost();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return 8'd0;
      if (r < 16) return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic set_reg(input csr_index_type idx, input int value);
      int v;
      v = value;
      if (idx == CSR_DISPARITY_COUNT)
         trk_count = ((v & 'h7F) == 0) ? 1 : ((v & 'h7F) > 64) ? 64 : (v & 'h7F);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= v[CSR_DATA_W-1:0];
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (words_in_flight != 0) @(negedge clock);
   endtask

   // send one disparity word; force a path start where the same or a neighbour entry holds no data yet
   task automatic put_disparity(input logic [7:0] raw, input logic [7:0] gray, input bit start);
      int d;
      int gap;
      int r;
      bit st;
      d  = trk_pos;
      st = start;
      if (!st && (!prev_seen[d] || (d > 0 && !prev_seen[d - 1]) ||
                  (d + 1 < trk_count && !prev_seen[d + 1])))
         st = 1'b1;
      curr_seen[d] = 1'b1;
      if (d + 1 >= trk_count) begin
         prev_seen = curr_seen;
         trk_pos   = 0;
         pixels_sent++;
      end else begin
         trk_pos = d + 1;
      end
      last_gray = gray;
      words_sent++;
      r   = $urandom_range(0, 99);
      gap = (!idling_on || r < 55) ? 0 : (r < 90) ? $urandom_range(1, 3)
                                                  : $urandom_range(6, 30);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_word  <= '{raw_cost: raw, pixel_gray: gray, path_start: st};
      do @(posedge clock); while (req_stall);
   endtask

   initial begin : stimulus
      int         r;
      int         budget;
      int         phase_start;
      logic [7:0] gray;
      bit         start;
      bit         mixed_gray;
      bit         mixed_start;

      reset        = 1'b1;
      csr_write_en = 1'b0;
      csr_index    = CSR_PENALTY_SMALL;
      csr_wdata    = '0;
      req_valid    = 1'b0;
      req_word     = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_reg(CSR_DISPARITY_COUNT, 2);
      set_reg(CSR_PENALTY_SMALL, 0);
      set_reg(CSR_PENALTY_LARGE_BASE, 1023);
      settings_used++;
      // pass through on a path start, then largest gray step, then equal gray
      put_disparity(8'd0,   8'd0,   1'b1);
      put_disparity(8'hFF,  8'd0,   1'b1);
      put_disparity(8'hFF,  8'hFF,  1'b0);
      put_disparity(8'd0,   8'hFF,  1'b0);
      put_disparity(8'd0,   8'hFF,  1'b0);
      put_disparity(8'd0,   8'hFF,  1'b0);
      drain_results();
      set_reg(CSR_PENALTY_SMALL, 255);
      set_reg(CSR_PENALTY_LARGE_BASE, 0);
      settings_used++;
      put_disparity(8'hFF,  8'd128, 1'b0);
      put_disparity(8'hFF,  8'd128, 1'b0);
      // gray and path flag changing inside one pixel
      put_disparity(8'd17,  8'd10,  1'b0);
      put_disparity(8'd200, 8'd200, 1'b0);
      put_disparity(8'd3,   8'd90,  1'b1);
      put_disparity(8'd4,   8'd90,  1'b0);
      put_disparity(8'd5,   8'd91,  1'b0);
      put_disparity(8'd6,   8'd91,  1'b1);
      drain_results();
      set_reg(CSR_DISPARITY_COUNT, 4);
      settings_used++;
      repeat (4) put_disparity(pick_cost(), 8'd40, 1'b1);
      repeat (2) put_disparity(pick_cost(), 8'd60, 1'b0);
      // shrink the count in the middle of a pixel
      drain_results();
      set_reg(CSR_DISPARITY_COUNT, 1);
      settings_used++;
      put_disparity(pick_cost(), 8'd61, 1'b0);
      drain_results();
      set_reg(CSR_DISPARITY_COUNT, 0);
      settings_used++;
      repeat (2) put_disparity(pick_cost(), 8'd250, 1'b0);

      while (words_sent < 1650) begin
         drain_results();
         if ($urandom_range(0, 1)) begin
            r = $urandom_range(0, 9);
            set_reg(CSR_PENALTY_SMALL, (r == 0) ? 0 : (r == 1) ? 255 :
                    (r < 6) ? $urandom_range(1, 40) : $urandom_range(0, 255));
         end
         if ($urandom_range(0, 1)) begin
            r = $urandom_range(0, 9);
            set_reg(CSR_PENALTY_LARGE_BASE, (r == 0) ? 0 : (r == 1) ? 1023 :
                    $urandom_range(0, 1023));
         end
         if ($urandom_range(0, 1)) begin
            r = $urandom_range(0, 19);
            set_reg(CSR_DISPARITY_COUNT, (r == 0) ? 0 : (r == 1) ? 127 : (r == 2) ? 64 :
                    (r == 3) ? $urandom_range(65, 126) :
                    (r < 12) ? $urandom_range(1, 4) : $urandom_range(5, 24));
         end
         settings_used++;
         idling_on   = ($urandom_range(0, 4) != 0);
         rsp_free    = ($urandom_range(0, 4) == 0);
         budget      = $urandom_range(40, 160);
         phase_start = words_sent;
         while (words_sent - phase_start < budget) begin
            r           = $urandom_range(0, 99);
            gray        = (r < 20) ? last_gray : (r < 25) ? 8'd0 : (r < 30) ? 8'hFF :
                          8'($urandom_range(0, 255));
            start       = ($urandom_range(0, 99) < 8);
            mixed_gray  = ($urandom_range(0, 99) < 5);
            mixed_start = ($urandom_range(0, 99) < 4);
            do
               put_disparity(pick_cost(),
                             mixed_gray ? 8'($urandom_range(0, 255)) : gray,
                             mixed_start ? 1'($urandom_range(0, 1)) : start);
            while (trk_pos != 0);
         end
         // send up to one pixel's words so the next register write can land mid-pixel
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, trk_count)) put_disparity(pick_cost(), last_gray, 1'b0);
      end

      drain_results();
      repeat (40) @(negedge clock);
      $display("Covered %0d cost words in %0d pixels over %0d register settings,",
               words_sent, pixels_sent, settings_used);
      $display("with path starts, gray steps and disparity count changes inside pixels.");
      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ===== sim.f =====
design/sgmpca_pkg.sv
design/sgmpca_front.sv
design/sgmpca_queue.sv
design/sgmpca_back.sv
design/sgm_path_cost_aggregation.sv
sim/sgm_cost_checker.sv
sim/tb_top.sv
